### hdl/rau_pkg.sv
`default_nettype none

package rau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Classification of one item, produced by the front and consumed by the back.
    typedef struct packed {
        t_op  op;
        logic err;
        logic an_neg;
        logic ad_neg;
        logic bn_neg;
        logic bd_neg;
    } t_cls;

    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;
    localparam int Q_DEPTH   = 2;

endpackage

`default_nettype wire

### hdl/rau_front.sv
`default_nettype none

module rau_front #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic [1:0]                       i_operation,
    input  logic signed [OPERAND_WIDTH-1:0]  i_left_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]  i_left_denominator,
    input  logic signed [OPERAND_WIDTH-1:0]  i_right_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]  i_right_denominator,
    output rau_pkg::t_cls                    o_cls,
    output logic [4*OPERAND_WIDTH-1:0]       o_mags
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? W'(~v + W'(1)) : v;
    endfunction

    t_op            op;
    logic [W-1:0]   an_mag;
    logic [W-1:0]   ad_mag;
    logic [W-1:0]   bn_mag;
    logic [W-1:0]   bd_mag;

    always_comb begin
        op     = t_op'(i_operation);
        an_mag = f_mag(i_left_numerator);
        ad_mag = f_mag(i_left_denominator);
        bn_mag = f_mag(i_right_numerator);
        bd_mag = f_mag(i_right_denominator);

        o_cls.op     = op;
        o_cls.err    = (i_left_denominator == '0) || (i_right_denominator == '0) ||
                       ((op == OP_DIV) && (i_right_numerator == '0));
        o_cls.an_neg = i_left_numerator[W-1];
        o_cls.ad_neg = i_left_denominator[W-1];
        o_cls.bd_neg = i_right_denominator[W-1];
        // Subtraction is carried out as addition of the negated right operand.
        if (op == OP_SUB) begin
            o_cls.bn_neg = !i_right_numerator[W-1] && (i_right_numerator != '0);
        end else begin
            o_cls.bn_neg = i_right_numerator[W-1];
        end

        o_mags = {an_mag, ad_mag, bn_mag, bd_mag};
    end

endmodule

`default_nettype wire

### hdl/rau_fifo.sv
`default_nettype none

module rau_fifo #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]         r_wr_ptr;
    logic [AW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_count;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(DEPTH - 1)) ? '0 : AW'(p + AW'(1));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

endmodule

`default_nettype wire

### hdl/rau_back.sv
`default_nettype none

module rau_back #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_empty,
    input  rau_pkg::t_cls                         i_cls,
    input  logic [4*OPERAND_WIDTH-1:0]            i_mags,
    output logic                                  o_pop,
    output logic                                  o_valid,
    output logic signed [rau_pkg::RES_NUM_W-1:0]  o_result_numerator,
    output logic [rau_pkg::RES_DEN_W-1:0]         o_result_denominator,
    output logic                                  o_error
);
    import rau_pkg::*;

    localparam int W   = OPERAND_WIDTH;
    localparam int MW  = 2 * W;
    localparam int CW  = $clog2(MW);
    localparam int XW  = (MW + 1 > RES_NUM_W) ? MW + 1 : RES_NUM_W;
    localparam int DXW = (MW > RES_DEN_W) ? MW : RES_DEN_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL0 = 8'b0000_0010,
        S_MUL1 = 8'b0000_0100,
        S_MUL2 = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_GCD  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    t_cls                   r_cls;
    logic [W-1:0]           r_an;
    logic [W-1:0]           r_ad;
    logic [W-1:0]           r_bn;
    logic [W-1:0]           r_bd;
    logic [MW-1:0]          r_p0;
    logic [MW-1:0]          r_p1;
    logic [MW-1:0]          r_p2;
    logic [MW-1:0]          r_num;
    logic [MW-1:0]          r_den;
    logic [MW-1:0]          r_u;
    logic [MW-1:0]          r_v;
    logic [CW-1:0]          r_k;
    logic [MW-1:0]          r_g;
    logic [MW-1:0]          r_rn;
    logic [MW-1:0]          r_rd;
    logic [CW-1:0]          r_cnt;
    logic                   r_neg;
    logic                   r_valid;
    logic [RES_NUM_W-1:0]   r_onum;
    logic [RES_DEN_W-1:0]   r_oden;
    logic                   r_oerr;

    logic [W-1:0]           mul_a;
    logic [W-1:0]           mul_b;
    logic [MW-1:0]          prod;
    logic                   add_op;
    logic                   s0;
    logic                   s1;
    logic [MW-1:0]          sum_mag;
    logic                   sum_neg;
    logic [MW-1:0]          den_mag;
    logic                   den_neg;
    logic [MW:0]            u_minus_v;
    logic [MW:0]            v_minus_u;
    logic [MW-1:0]          gcd_u;
    logic [MW-1:0]          gcd_v;
    logic [CW-1:0]          gcd_k;
    logic [MW:0]            rn_sh;
    logic [MW:0]            rn_diff;
    logic [MW:0]            rd_sh;
    logic [MW:0]            rd_diff;
    logic                   qn;
    logic                   qd;
    logic signed [MW:0]     nf_s;
    logic signed [XW-1:0]   nf_x;
    logic [DXW-1:0]         den_x;
    logic                   fin;
    logic [RES_NUM_W-1:0]   fin_num;
    logic [RES_DEN_W-1:0]   fin_den;
    logic                   fin_err;

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign add_op = (r_cls.op == OP_ADD) || (r_cls.op == OP_SUB);

    // One shared multiplier, fed a different operand pair in each multiply state.
    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        case (r_state)
            S_MUL0: begin
                mul_a = r_an;
                mul_b = (r_cls.op == OP_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                mul_a = r_ad;
                mul_b = (r_cls.op == OP_MUL) ? r_bd : r_bn;
            end
            S_MUL2: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
            default: begin
                mul_a = r_an;
                mul_b = r_bd;
            end
        endcase
    end

    assign prod = MW'(mul_a) * MW'(mul_b);

    // Signed combination of the products into numerator and denominator.
    always_comb begin
        s0 = r_cls.an_neg ^ ((r_cls.op == OP_MUL) ? r_cls.bn_neg : r_cls.bd_neg);
        s1 = r_cls.bn_neg ^ r_cls.ad_neg;
        if (add_op) begin
            if (s0 == s1) begin
                sum_mag = r_p0 + r_p1;
                sum_neg = s0;
            end else if (r_p0 >= r_p1) begin
                sum_mag = r_p0 - r_p1;
                sum_neg = s0;
            end else begin
                sum_mag = r_p1 - r_p0;
                sum_neg = s1;
            end
            den_mag = r_p2;
            den_neg = r_cls.ad_neg ^ r_cls.bd_neg;
        end else begin
            sum_mag = r_p0;
            sum_neg = s0;
            den_mag = r_p1;
            den_neg = r_cls.ad_neg ^ ((r_cls.op == OP_DIV) ? r_cls.bn_neg : r_cls.bd_neg);
        end
    end

    // One binary GCD step per cycle. The common power of two is counted in k.
    always_comb begin
        u_minus_v = {1'b0, r_u} - {1'b0, r_v};
        v_minus_u = {1'b0, r_v} - {1'b0, r_u};
        gcd_u     = r_u;
        gcd_v     = r_v;
        gcd_k     = r_k;
        if (!r_u[0] && !r_v[0]) begin
            gcd_u = r_u >> 1;
            gcd_v = r_v >> 1;
            gcd_k = r_k + CW'(1);
        end else if (!r_u[0]) begin
            gcd_u = r_u >> 1;
        end else if (!r_v[0]) begin
            gcd_v = r_v >> 1;
        end else if (r_u > r_v) begin
            gcd_u = {1'b0, u_minus_v[MW-1:1]};
        end else begin
            gcd_v = {1'b0, v_minus_u[MW-1:1]};
        end
    end

    // Restoring division of numerator and denominator by the GCD, one bit each.
    always_comb begin
        rn_sh   = {r_rn, r_num[MW-1]};
        rn_diff = rn_sh - {1'b0, r_g};
        qn      = !rn_diff[MW];
        rd_sh   = {r_rd, r_den[MW-1]};
        rd_diff = rd_sh - {1'b0, r_g};
        qd      = !rd_diff[MW];
    end

    assign nf_s  = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
    assign nf_x  = XW'(nf_s);
    assign den_x = DXW'(r_den);

    always_comb begin
        fin     = 1'b0;
        fin_num = '0;
        fin_den = RES_DEN_W'(1);
        fin_err = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_pop && i_cls.err) begin
                    fin     = 1'b1;
                    fin_err = 1'b1;
                end
            end
            S_SUM: begin
                if (sum_mag == '0) begin
                    fin = 1'b1;
                end
            end
            S_DONE: begin
                fin     = 1'b1;
                fin_num = nf_x[RES_NUM_W-1:0];
                fin_den = den_x[RES_DEN_W-1:0];
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop && !i_cls.err) begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = add_op ? S_MUL2 : S_SUM;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = (sum_mag == '0) ? S_IDLE : S_GCD;
            S_GCD: begin
                if (r_v == '0) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CW'(MW - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_cls                    <= i_cls;
                    {r_an, r_ad, r_bn, r_bd} <= i_mags;
                end
            end
            S_MUL0: r_p0 <= prod;
            S_MUL1: r_p1 <= prod;
            S_MUL2: r_p2 <= prod;
            S_SUM: begin
                r_num <= sum_mag;
                r_den <= den_mag;
                r_u   <= sum_mag;
                r_v   <= den_mag;
                r_k   <= '0;
                r_neg <= sum_neg ^ den_neg;
            end
            S_GCD: begin
                if (r_v == '0) begin
                    r_g   <= MW'(r_u << r_k);
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_cnt <= '0;
                end else begin
                    r_u <= gcd_u;
                    r_v <= gcd_v;
                    r_k <= gcd_k;
                end
            end
            S_DIV: begin
                r_num <= {r_num[MW-2:0], qn};
                r_den <= {r_den[MW-2:0], qd};
                r_rn  <= qn ? rn_diff[MW-1:0] : rn_sh[MW-1:0];
                r_rd  <= qd ? rd_diff[MW-1:0] : rd_sh[MW-1:0];
                r_cnt <= r_cnt + CW'(1);
            end
            default: begin
            end
        endcase
        if (fin) begin
            r_onum <= fin_num;
            r_oden <= fin_den;
            r_oerr <= fin_err;
        end
    end

    assign o_valid              = r_valid;
    assign o_result_numerator   = r_onum;
    assign o_result_denominator = r_oden;
    assign o_error              = r_oerr;

endmodule

`default_nettype wire

### hdl/rational_arithmetic_unit.sv
// Error items are reported from the idle state without entering the multiply/GCD/divide steps.
// The single back-end GCD/divide sequencer works on one item at a time and pops the next only when idle.
// A two-entry queue sits in front of it; busy is high while that queue is full.
// o_valid pulses for one cycle per result; the receiver cannot stall.
// i_rst_n is synchronous and active low; it empties the queue and idles the sequencer.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_operation,
    input  logic signed [OPERAND_WIDTH-1:0]       i_left_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]       i_left_denominator,
    input  logic signed [OPERAND_WIDTH-1:0]       i_right_numerator,
    input  logic signed [OPERAND_WIDTH-1:0]       i_right_denominator,
    output logic                                  o_valid,
    output logic signed [rau_pkg::RES_NUM_W-1:0]  o_result_numerator,
    output logic [rau_pkg::RES_DEN_W-1:0]         o_result_denominator,
    output logic                                  o_error
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CB = $bits(t_cls);
    localparam int DW = CB + 4 * W;

    t_cls           in_cls;
    logic [4*W-1:0] in_mags;
    logic [DW-1:0]  head;
    t_cls           head_cls;
    logic [4*W-1:0] head_mags;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;

    rau_front #(
        .OPERAND_WIDTH(W)
    ) u_front (
        .i_operation        (i_operation),
        .i_left_numerator   (i_left_numerator),
        .i_left_denominator (i_left_denominator),
        .i_right_numerator  (i_right_numerator),
        .i_right_denominator(i_right_denominator),
        .o_cls              (in_cls),
        .o_mags             (in_mags)
    );

    assign push = start && !busy;

    rau_fifo #(
        .DATA_WIDTH(DW),
        .DEPTH     (Q_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({in_cls, in_mags}),
        .i_pop  (pop),
        .o_data (head),
        .o_empty(empty),
        .o_full (full)
    );

    assign busy      = full;
    assign head_cls  = t_cls'(head[DW-1 -: CB]);
    assign head_mags = head[4*W-1:0];

    rau_back #(
        .OPERAND_WIDTH(W)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (empty),
        .i_cls               (head_cls),
        .i_mags              (head_mags),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .o_result_numerator  (o_result_numerator),
        .o_result_denominator(o_result_denominator),
        .o_error             (o_error)
    );

endmodule

`default_nettype wire

### hdl/rau_checker.sv
`default_nettype none

module rau_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  busy,
    input logic                                  o_valid,
    input logic signed [rau_pkg::RES_NUM_W-1:0]  o_result_numerator,
    input logic [rau_pkg::RES_DEN_W-1:0]         o_result_denominator,
    input logic                                  o_error
);
    import rau_pkg::*;

    // A failed beat always reports the fixed 0/1 pattern.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |->
            (o_result_numerator == '0) && (o_result_denominator == RES_DEN_W'(1)))
        else $error("error result is not 0/1");

    // A zero result is reported with denominator one.
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_numerator == '0) |-> (o_result_denominator == RES_DEN_W'(1)))
        else $error("zero result not normalized to 0/1");

    // Reduced fractions never have both parts even.
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |-> o_result_numerator[0] || o_result_denominator[0])
        else $error("result fraction not fully reduced");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("outputs not idle after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

`default_nettype wire
